/* rtl/best_fit_buffer_pool_macros.svh */
// Assertion macros shared by the buffer pool RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef BEST_FIT_BUFFER_POOL_MACROS_SVH
`define BEST_FIT_BUFFER_POOL_MACROS_SVH

// A condition that must hold at every clock edge.
`define BFBP_ASSERT_HOLD(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define BFBP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define BFBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bfbp_pkg.sv */
// Shared constants, codes and types of the best-fit buffer pool.
// Depends on nothing; every other file of the block but the assertion macros header imports it.
package bfbp_pkg;

    localparam int DEF_POOL_SLOTS = 16;
    localparam int DEF_SIZE_BITS  = 32;

    localparam int OP_W     = 2;
    localparam int REQ_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int HOW_W    = 2;
    localparam int CAP_W    = 32;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CLEAR_REFUSED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_POOL_FULL     = 2'd3;

    localparam logic [HOW_W-1:0] HOW_BEST_FIT = 2'd0;
    localparam logic [HOW_W-1:0] HOW_GROWN    = 2'd1;
    localparam logic [HOW_W-1:0] HOW_APPENDED = 2'd2;

    // Which candidates the fit unit has found so far in a scan.
    typedef struct packed {
        logic have_best;
        logic have_big;
    } fit_flags_t;

endpackage

/* rtl/bfbp_if.sv */
// Valid/ready channels of the buffer pool: command words in, result words out.
// Depends on bfbp_pkg for the field widths.
interface bfbp_cmd_if
    import bfbp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [REQ_W-1:0]  request_size;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output operation, output request_size,
                    output slot_index, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input slot_index, output ready);
endinterface

interface bfbp_rsp_if
    import bfbp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [HOW_W-1:0]    how_granted;
    logic [CAP_W-1:0]    slot_capacity;

    modport source (output valid, output status, output granted_slot,
                    output how_granted, output slot_capacity, input ready);
    modport sink   (input valid, input status, input granted_slot,
                    input how_granted, input slot_capacity, output ready);
endinterface

/* rtl/best_fit_buffer_pool.sv */
// Best-fit buffer pool: top level with the slot memory, busy flags and the scan sequencer.
// Depends on bfbp_pkg, bfbp_if, bfbp_fit_unit and best_fit_buffer_pool_macros.svh.
//
// An acquire walks the existing slots one per cycle through a single compare unit,
// reading capacities from a one-port-read memory with a registered output, so it
// passes through the scan, drain and finish states; with an empty pool it goes
// straight to finish, as do release, clear and the unused code. The
// command channel is ready only while the sequencer is idle; a finished result sits
// in an output register so the next command can be taken while it waits. No
// clearing pass is needed after reset: a capacity is read only for slots that exist.
`include "best_fit_buffer_pool_macros.svh"

module best_fit_buffer_pool
    import bfbp_pkg::*;
#(
    parameter int POOL_SLOTS = DEF_POOL_SLOTS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    bfbp_cmd_if.sink    cmd,
    bfbp_rsp_if.source  rsp
);

    localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam int REL_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_t;

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    logic [SLOT_W-1:0]       rel_idx_reg, rel_idx_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                    cand_valid_reg, cand_valid_next;
    logic [IDX_W-1:0]        cand_idx_reg, cand_idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        busy_cnt_reg, busy_cnt_next;
    logic [POOL_SLOTS-1:0]   busy_reg, busy_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [SLOT_W-1:0]       out_slot_reg, out_slot_next;
    logic [HOW_W-1:0]        out_how_reg, out_how_next;
    logic [CAP_W-1:0]        out_cap_reg, out_cap_next;

    logic [SIZE_BITS-1:0]    slot_cap_mem [POOL_SLOTS];
    logic [SIZE_BITS-1:0]    rd_data_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [SIZE_BITS-1:0]    mem_wdata;

    fit_flags_t              fit_flags;
    logic [IDX_W-1:0]        best_idx, big_idx;
    logic [SIZE_BITS-1:0]    best_cap;
    logic                    fit_start;
    logic                    cand_free;

    logic                    accept;
    logic                    load;
    logic [STATUS_W-1:0]     res_status;
    logic [IDX_W-1:0]        res_slot;
    logic [HOW_W-1:0]        res_how;
    logic [SIZE_BITS-1:0]    res_cap;
    logic [SIZE_BITS-1:0]    req_trunc;
    logic [IDX_W-1:0]        rel_slot;
    logic                    rel_ok;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign fit_start = accept;
    assign cand_free = cand_valid_reg && !busy_reg[cand_idx_reg];
    assign req_trunc = SIZE_BITS'(req_reg);
    assign rel_slot  = IDX_W'(rel_idx_reg);
    assign rel_ok    = (REL_W'(rel_idx_reg) < REL_W'(count_reg)) && busy_reg[rel_slot];
    assign load      = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    bfbp_fit_unit #(
        .IDX_W     (IDX_W),
        .SIZE_BITS (SIZE_BITS)
    ) u_fit (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (fit_start),
        .cand_valid (cand_free),
        .cand_idx   (cand_idx_reg),
        .cand_cap   (rd_data_reg),
        .req        (req_reg),
        .flags      (fit_flags),
        .best_idx   (best_idx),
        .best_cap   (best_cap),
        .big_idx    (big_idx)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_cap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_cap_mem[scan_idx_reg];
    end

    // Outcome of the finished command; applied only in the cycle it is loaded out.
    always_comb
    begin
        res_status = STATUS_OK;
        res_slot   = '0;
        res_how    = HOW_BEST_FIT;
        res_cap    = '0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = req_trunc;
        case (op_reg)
            OP_ACQUIRE:
            begin
                if (fit_flags.have_best)
                begin
                    res_slot = best_idx;
                    res_cap  = best_cap;
                end
                else if (fit_flags.have_big)
                begin
                    res_slot  = big_idx;
                    res_how   = HOW_GROWN;
                    res_cap   = req_trunc;
                    mem_we    = load;
                    mem_waddr = big_idx;
                end
                else if (count_reg < CNT_W'(POOL_SLOTS))
                begin
                    res_slot  = IDX_W'(count_reg);
                    res_how   = HOW_APPENDED;
                    res_cap   = req_trunc;
                    mem_we    = load;
                    mem_waddr = IDX_W'(count_reg);
                end
                else
                begin
                    res_status = STATUS_POOL_FULL;
                end
            end
            OP_RELEASE:
            begin
                if (!rel_ok)
                begin
                    res_status = STATUS_BAD_RELEASE;
                end
            end
            OP_CLEAR:
            begin
                if (busy_cnt_reg != '0)
                begin
                    res_status = STATUS_CLEAR_REFUSED;
                end
            end
            default:
            begin
                res_status = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        rel_idx_next    = rel_idx_reg;
        scan_idx_next   = scan_idx_reg;
        cand_valid_next = 1'b0;
        cand_idx_next   = cand_idx_reg;
        count_next      = count_reg;
        busy_cnt_next   = busy_cnt_reg;
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_how_next    = out_how_reg;
        out_cap_next    = out_cap_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = cmd.operation;
                    req_next      = cmd.request_size;
                    rel_idx_next  = cmd.slot_index;
                    scan_idx_next = '0;
                    if (cmd.operation == OP_ACQUIRE && count_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                // The read issued now returns next cycle, tagged by cand_idx.
                cand_valid_next = 1'b1;
                cand_idx_next   = scan_idx_reg;
                if (CNT_W'(scan_idx_reg) == count_reg - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = res_status;
                    out_slot_next   = SLOT_W'(res_slot);
                    out_how_next    = res_how;
                    out_cap_next    = CAP_W'(res_cap);
                    if (op_reg == OP_ACQUIRE && res_status == STATUS_OK)
                    begin
                        busy_next[res_slot] = 1'b1;
                        busy_cnt_next       = busy_cnt_reg + CNT_W'(1);
                        if (res_how == HOW_APPENDED)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (op_reg == OP_RELEASE && res_status == STATUS_OK)
                    begin
                        busy_next[rel_slot] = 1'b0;
                        busy_cnt_next       = busy_cnt_reg - CNT_W'(1);
                    end
                    else if (op_reg == OP_CLEAR && res_status == STATUS_OK)
                    begin
                        busy_next  = '0;
                        count_next = '0;
                    end
                    // Results other than a granted acquire carry zero slot, how and capacity.
                    if (!(op_reg == OP_ACQUIRE && res_status == STATUS_OK))
                    begin
                        out_slot_next = '0;
                        out_how_next  = HOW_BEST_FIT;
                        out_cap_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cand_valid_reg <= 1'b0;
            count_reg      <= '0;
            busy_cnt_reg   <= '0;
            busy_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            req_reg        <= req_next;
            rel_idx_reg    <= rel_idx_next;
            scan_idx_reg   <= scan_idx_next;
            cand_valid_reg <= cand_valid_next;
            cand_idx_reg   <= cand_idx_next;
            count_reg      <= count_next;
            busy_cnt_reg   <= busy_cnt_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_how_reg    <= out_how_next;
            out_cap_reg    <= out_cap_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.granted_slot  = out_slot_reg;
    assign rsp.how_granted   = out_how_reg;
    assign rsp.slot_capacity = out_cap_reg;

    `BFBP_ASSERT_HOLD(a_busy_within_count, busy_cnt_reg <= count_reg,
                      "more busy slots than slots")
    `BFBP_ASSERT_HOLD(a_count_in_range, count_reg <= CNT_W'(POOL_SLOTS),
                      "slot count past pool size")
    `BFBP_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE,
                      "accepted word not worked on")
    `BFBP_ASSERT_IMPL(a_scan_in_pool, state_reg == ST_SCAN, CNT_W'(scan_idx_reg) < count_reg,
                      "scan ran past the last slot")

endmodule

/* rtl/bfbp_fit_unit.sv */
// Shared compare unit of the pool scan: tracks the best-fitting and the largest free slot.
// Depends on bfbp_pkg; fed one slot per cycle by the top level's sequencer, busy slots marked invalid.
module bfbp_fit_unit
    import bfbp_pkg::*;
#(
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = DEF_SIZE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cand_valid,
    input  logic [IDX_W-1:0]     cand_idx,
    input  logic [SIZE_BITS-1:0] cand_cap,
    input  logic [REQ_W-1:0]     req,
    output fit_flags_t           flags,
    output logic [IDX_W-1:0]     best_idx,
    output logic [SIZE_BITS-1:0] best_cap,
    output logic [IDX_W-1:0]     big_idx
);

    localparam int CMP_W = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

    fit_flags_t           flags_reg, flags_next;
    logic [IDX_W-1:0]     best_idx_reg, big_idx_reg;
    logic [SIZE_BITS-1:0] best_cap_reg, big_cap_reg;
    logic                 take_best, take_big;

    // The fit test compares against the full request, not the stored width.
    always_comb
    begin
        take_best = cand_valid && (CMP_W'(cand_cap) >= CMP_W'(req))
                    && (!flags_reg.have_best || cand_cap < best_cap_reg);
        take_big  = cand_valid && (!flags_reg.have_big || big_cap_reg < cand_cap);
        flags_next = flags_reg;
        if (start)
        begin
            flags_next = '0;
        end
        else
        begin
            if (take_best)
            begin
                flags_next.have_best = 1'b1;
            end
            if (take_big)
            begin
                flags_next.have_big = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!start && take_best)
        begin
            best_idx_reg <= cand_idx;
            best_cap_reg <= cand_cap;
        end
        if (!start && take_big)
        begin
            big_idx_reg <= cand_idx;
            big_cap_reg <= cand_cap;
        end
    end

    assign flags    = flags_reg;
    assign best_idx = best_idx_reg;
    assign best_cap = best_cap_reg;
    assign big_idx  = big_idx_reg;

endmodule

/* tb/sv/best_fit_buffer_pool_tb.sv */
// Self-checking testbench of best_fit_buffer_pool: directed, then random command words under random idling.
// Depends on bfbp_pkg, the bfbp_cmd_if and bfbp_rsp_if channels and the block itself.
// A shadow copy of the pool predicts each result word; a scoreboard class checks them.
module best_fit_buffer_pool_tb
    import bfbp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SLOTS   = DEF_POOL_SLOTS;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [HOW_W-1:0]    how;
        logic [CAP_W-1:0]    cap;
    } pool_outcome_t;

    // Shadow of the pool plus the queue of result words still to come.
    class pool_tracker;
        logic [CAP_W-1:0] capacity [POOL_SLOTS];
        bit               busy [POOL_SLOTS];
        int unsigned      slots_made;
        pool_outcome_t    awaited_outcomes [$];
        int unsigned      mismatches;

        function new();
            foreach (busy[i])
                busy[i] = 1'b0;
            slots_made = 0;
            mismatches = 0;
        endfunction

        function pool_outcome_t pool_outcome(logic [OP_W-1:0] op, logic [REQ_W-1:0] req,
                                             logic [SLOT_W-1:0] idx);
            pool_outcome_t res;
            bit            have_best;
            bit            have_big;
            bit            any_busy;
            int            best;
            int            big;
            res       = '0;
            have_best = 1'b0;
            have_big  = 1'b0;
            any_busy  = 1'b0;
            best      = 0;
            big       = 0;
            case (op)
                OP_ACQUIRE:
                begin
                    for (int i = 0; i < slots_made; i++)
                    begin
                        if (!busy[i])
                        begin
                            if (!have_big || capacity[big] < capacity[i])
                            begin
                                big      = i;
                                have_big = 1'b1;
                            end
                            if (capacity[i] >= req && (!have_best || capacity[i] < capacity[best]))
                            begin
                                best      = i;
                                have_best = 1'b1;
                            end
                        end
                    end
                    if (have_best)
                    begin
                        busy[best] = 1'b1;
                        res.slot   = SLOT_W'(best);
                        res.how    = HOW_BEST_FIT;
                        res.cap    = capacity[best];
                    end
                    else if (have_big)
                    begin
                        capacity[big] = req[CAP_W-1:0];
                        busy[big]     = 1'b1;
                        res.slot      = SLOT_W'(big);
                        res.how       = HOW_GROWN;
                        res.cap       = capacity[big];
                    end
                    else if (slots_made < POOL_SLOTS)
                    begin
                        capacity[slots_made] = req[CAP_W-1:0];
                        busy[slots_made]     = 1'b1;
                        res.slot             = SLOT_W'(slots_made);
                        res.how              = HOW_APPENDED;
                        res.cap              = capacity[slots_made];
                        slots_made++;
                    end
                    else
                        res.status = STATUS_POOL_FULL;
                end
                OP_RELEASE:
                begin
                    if (idx < slots_made && busy[idx])
                        busy[idx] = 1'b0;
                    else
                        res.status = STATUS_BAD_RELEASE;
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < slots_made; i++)
                        if (busy[i])
                            any_busy = 1'b1;
                    if (any_busy)
                        res.status = STATUS_CLEAR_REFUSED;
                    else
                        slots_made = 0;
                end
                default:
                    ;
            endcase
            return res;
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [REQ_W-1:0] req,
                                   logic [SLOT_W-1:0] idx);
            awaited_outcomes.push_back(pool_outcome(op, req, idx));
        endfunction

        function void check_outcome(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                    logic [HOW_W-1:0] how, logic [CAP_W-1:0] cap);
            pool_outcome_t want;
            if (awaited_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result word: status %0d slot %0d how %0d cap %h",
                             $realtime, status, slot, how, cap);
                return;
            end
            want = awaited_outcomes.pop_front();
            if (status !== want.status || slot !== want.slot || how !== want.how ||
                cap !== want.cap)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: status %0d/%0d slot %0d/%0d how %0d/%0d cap %h/%h",
                             $realtime, want.status, status, want.slot, slot, want.how, how,
                             want.cap, cap);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    bit          calm;
    int unsigned commands_sent;
    int unsigned quiet_cycles;
    pool_tracker tracker;

    bfbp_cmd_if cmd_ch ();
    bfbp_rsp_if rsp_ch ();

    best_fit_buffer_pool i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int idle_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Small sizes give frequent fits and ties; wide ones exercise growth and the extremes.
    function automatic logic [REQ_W-1:0] draw_request_size();
        int r;
        r = $urandom_range(99, 0);
        if (r < 5)
            return '0;
        if (r < 50)
            return REQ_W'($urandom_range(16, 1));
        if (r < 70)
            return REQ_W'($urandom_range(4096, 1));
        if (r < 95)
            return REQ_W'($urandom);
        return '1;
    endfunction

    task automatic issue_command(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                                 input logic [SLOT_W-1:0] idx);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.operation    = op;
        cmd_ch.request_size = req;
        cmd_ch.slot_index   = idx;
        cmd_ch.valid        = 1'b1;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        tracker.note_command(op, req, idx);
        commands_sent++;
    endtask

    // Result side: ready drops for random stretches.
    initial
    begin
        int stall;
        stall        = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                stall        = idle_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_outcome(rsp_ch.status, rsp_ch.granted_slot, rsp_ch.how_granted,
                                  rsp_ch.slot_capacity);
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("best_fit_buffer_pool test failed");
            $finish;
        end
    end

    initial
    begin
        int          r;
        int          start;
        int          pick;
        int unsigned target;
        int unsigned next_toggle;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        calm                = 1'b0;
        commands_sent       = 0;
        quiet_cycles        = 0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.operation    = OP_ACQUIRE;
        cmd_ch.request_size = '0;
        cmd_ch.slot_index   = '0;
        tracker             = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pool, appends at both size extremes, refused clear, bad releases,
        // best fit, growth of the largest free slot, and a full pool.
        issue_command(OP_RELEASE, '0, 4'd3);
        issue_command(OP_UNUSED, REQ_W'($urandom), SLOT_W'($urandom));
        issue_command(OP_CLEAR, '0, '0);
        issue_command(OP_ACQUIRE, '0, '0);
        issue_command(OP_ACQUIRE, '1, '1);
        issue_command(OP_ACQUIRE, 32'd100, '0);
        issue_command(OP_CLEAR, '1, '1);
        issue_command(OP_RELEASE, '0, 4'd1);
        issue_command(OP_RELEASE, '0, 4'd1);
        issue_command(OP_RELEASE, '1, 4'd15);
        issue_command(OP_ACQUIRE, 32'd50, '0);
        issue_command(OP_RELEASE, '0, 4'd0);
        issue_command(OP_RELEASE, '0, 4'd2);
        issue_command(OP_ACQUIRE, 32'd60, '0);
        issue_command(OP_ACQUIRE, 32'd200, '0);
        repeat (POOL_SLOTS - 2)
            issue_command(OP_ACQUIRE, REQ_W'($urandom), '0);

        target      = commands_sent + RANDOM_ITEMS;
        next_toggle = commands_sent + 128;
        while (commands_sent < target)
        begin
            if (commands_sent >= next_toggle)
            begin
                calm        = ($urandom_range(3, 0) == 0);
                next_toggle = commands_sent + 128;
            end
            r = $urandom_range(99, 0);
            if (r < 45)
                issue_command(OP_ACQUIRE, draw_request_size(), SLOT_W'($urandom));
            else if (r < 77)
            begin
                // Free a slot that is in use, found from a random starting point, or any slot if none is in use.
                pick  = -1;
                start = $urandom_range(POOL_SLOTS - 1, 0);
                for (int k = 0; k < POOL_SLOTS; k++)
                    if (pick < 0 && tracker.busy[(start + k) % POOL_SLOTS] &&
                        (start + k) % POOL_SLOTS < tracker.slots_made)
                        pick = (start + k) % POOL_SLOTS;
                if (pick < 0)
                    pick = $urandom_range(POOL_SLOTS - 1, 0);
                issue_command(OP_RELEASE, REQ_W'($urandom), SLOT_W'(pick));
            end
            else if (r < 87)
                issue_command(OP_RELEASE, REQ_W'($urandom), SLOT_W'($urandom));
            else if (r < 93)
                issue_command(OP_CLEAR, REQ_W'($urandom), SLOT_W'($urandom));
            else if (r < 96)
                issue_command(OP_UNUSED, REQ_W'($urandom), SLOT_W'($urandom));
            else
            begin
                // Give back every busy slot, then clear the emptied pool.
                for (int s = 0; s < POOL_SLOTS; s++)
                    if (tracker.busy[s] && s < tracker.slots_made)
                        issue_command(OP_RELEASE, REQ_W'($urandom), SLOT_W'(s));
                issue_command(OP_CLEAR, REQ_W'($urandom), SLOT_W'($urandom));
            end
        end
        @(negedge clk);
        cmd_ch.valid = 1'b0;

        while (tracker.awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.awaited_outcomes.size() == 0)
            $display("best_fit_buffer_pool test passed");
        else
            $display("best_fit_buffer_pool test failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bfbp_pkg.sv
rtl/bfbp_if.sv
rtl/bfbp_fit_unit.sv
rtl/best_fit_buffer_pool.sv
tb/sv/best_fit_buffer_pool_tb.sv
